FILE: hw/rtl/read_write_reorder_request_queue_core_defines.svh
// Assertion macros shared by the request queue RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk, disabled in rst.
`ifndef READ_WRITE_REORDER_REQUEST_QUEUE_CORE_DEFINES_SVH
`define READ_WRITE_REORDER_REQUEST_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication
`define RWRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RWRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rwrq_pkg.sv
// Types and constants of the read/write reorder request queue.
// No dependencies; used by rwrq_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rwrq_pkg;

  // Request operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;

  // Request kinds carried on s_tuser
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // Policy level that turns on read/write reordering
  localparam logic [1:0] POLICY_REORDER = 2'd3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OCC_W      = 5;

  // One queued request
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  bgroup;
    logic [1:0]  bank;
    logic [15:0] row;
    logic [5:0]  col_upper;
    logic [3:0]  col_lower;
  } entry_t;

  // What a cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
  } cell_ctrl_t;

  // Request broadcast to every cell for the partner search
  typedef struct packed {
    entry_t     req;
    logic [1:0] want_op;
  } cmp_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rwrq_cell.sv
// One queue slot: holds an entry, shifts with its neighbors and flags a reorder partner.
// Depends on rwrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwrq_cell
  import rwrq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     new_entry,
  input  wire entry_t     lower_entry,
  input  wire entry_t     upper_entry,
  input  wire cmp_req_t   cmp,
  input  wire logic       valid,
  output entry_t          entry,
  output logic            match
);

  // Load, shift or hold the slot contents
  always_ff @(posedge clk) begin
    case (ctrl.act)
      CELL_LOAD:       entry <= new_entry;
      CELL_SHIFT_UP:   entry <= lower_entry;
      CELL_SHIFT_DOWN: entry <= upper_entry;
      default:         entry <= entry;
    endcase
  end

  // Partner: wanted op, same bank group and bank, different address
  always_comb begin
    match = valid && (entry.op == cmp.want_op) &&
            (entry.bgroup == cmp.req.bgroup) &&
            (entry.bank == cmp.req.bank) &&
            ((entry.row != cmp.req.row) || (entry.col_upper != cmp.req.col_upper) ||
             (entry.col_lower != cmp.req.col_lower));
  end

endmodule

`default_nettype wire

FILE: hw/rtl/read_write_reorder_request_queue_core.sv
// Top level of the read/write reorder request queue: control FSM and a chain of slot cells.
// Depends on rwrq_pkg, rwrq_cell and read_write_reorder_request_queue_core_defines.svh.
//
//  channel  | signals                        | carries
//  ---------+--------------------------------+-------------------------------------
//  s_       | s_tvalid s_tready s_tdata/user | enqueue or dequeue request
//  m_       | m_tvalid m_tready m_tdata      | one result per request
//  config   | policy_level_we/_wdata         | policy level, write only
//
// In ST_IDLE the accept registers the per-cell partner compare; in ST_EXEC the item
// finds the first partner and shifts the cell chain.
// The output register holds a result until taken; ST_EXEC waits while it is full.
// rst clears the count, FSM, output valid and policy; slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "read_write_reorder_request_queue_core_defines.svh"

module read_write_reorder_request_queue_core
  import rwrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  policy_level_we,
  input  wire logic [1:0]            policy_level_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [1:0] request_op, [4:2] bgroup, [6:5] bank_index, [22:7] row_address,
  // [28:23] column_upper, [32:29] column_lower, [39:33] zero
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // [0] req_type
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] accepted, [1] head_valid, [3:2] head_op, [6:4] head_bgroup, [8:7] head_bank,
  // [24:9] head_row, [30:25] head_column_upper, [34:31] head_column_lower, [39:35] occupancy
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  state_t state, state_next;
  logic   commit;

  logic [1:0]  policy;
  logic [CW-1:0] count, count_next;

  // Captured item
  logic       req_is_deq;
  entry_t     req_entry;
  logic [QUEUE_DEPTH-1:0] hit;

  // Output register
  logic         out_accepted;
  logic         out_head_valid;
  entry_t       out_head;
  logic [OCC_W-1:0] out_occ;

  // Chain wiring
  entry_t     cell_entry [QUEUE_DEPTH];
  cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_match;
  logic [QUEUE_DEPTH-1:0] cell_valid;

  entry_t   in_entry;
  cmp_req_t cmp;
  logic     reorder_en;
  logic     queue_full;
  logic     hit_found;
  logic [IW-1:0] hit_idx;
  logic [CW-1:0] ins_pos;

  // Unpack the incoming request
  always_comb begin
    in_entry.op         = s_tdata[1:0];
    in_entry.bgroup     = s_tdata[4:2];
    in_entry.bank       = s_tdata[6:5];
    in_entry.row        = s_tdata[22:7];
    in_entry.col_upper  = s_tdata[28:23];
    in_entry.col_lower  = s_tdata[32:29];
    cmp.req             = in_entry;
    cmp.want_op         = (in_entry.op == OP_WRITE) ? OP_READ : OP_WRITE;
    reorder_en = (policy == POLICY_REORDER) && (s_tuser == REQ_ENQUEUE) &&
                 ((in_entry.op == OP_READ) || (in_entry.op == OP_WRITE));
  end

  // Policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= '0;
    end else if (policy_level_we) begin
      policy <= policy_level_wdata;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the item and the registered partner hits
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_is_deq <= s_tuser;
      req_entry  <= in_entry;
      hit        <= cell_match & {QUEUE_DEPTH{reorder_en}};
    end
  end

  // Find the first partner and the insert position
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_found = 1'b1;
        hit_idx   = IW'(i);
      end
    end
    if (!hit_found) begin
      ins_pos = count;
    end else if (req_entry.op == OP_WRITE) begin
      ins_pos = CW'(hit_idx) + CW'(1);
    end else begin
      ins_pos = CW'(hit_idx);
    end
  end

  assign queue_full = (count == DEPTH_CNT);

  // Per-cell action
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_ctrl[i].act = CELL_HOLD;
      if (commit && !req_is_deq && !queue_full) begin
        if (CW'(i) == ins_pos) begin
          cell_ctrl[i].act = CELL_LOAD;
        end else if (CW'(i) > ins_pos) begin
          cell_ctrl[i].act = CELL_SHIFT_UP;
        end
      end else if (commit && req_is_deq && (count != '0)) begin
        cell_ctrl[i].act = CELL_SHIFT_DOWN;
      end
    end
  end

  // Count after this item
  always_comb begin
    count_next = count;
    if (!req_is_deq && !queue_full) begin
      count_next = count + CW'(1);
    end else if (req_is_deq && (count != '0)) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_accepted   <= !req_is_deq && !queue_full;
      out_head_valid <= req_is_deq && (count != '0);
      out_head       <= (req_is_deq && (count != '0)) ? cell_entry[0] : '0;
      out_occ        <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {out_occ, out_head.col_lower, out_head.col_upper, out_head.row,
                    out_head.bank, out_head.bgroup, out_head.op,
                    out_head_valid, out_accepted};

  // Chain of slot cells
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t lower, upper;
    if (g == 0) begin : g_first
      assign lower = cell_entry[g];
    end else begin : g_mid_lo
      assign lower = cell_entry[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign upper = cell_entry[g];
    end else begin : g_mid_hi
      assign upper = cell_entry[g+1];
    end
    assign cell_valid[g] = (CW'(g) < count);

    rwrq_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[g]),
      .new_entry   (req_entry),
      .lower_entry (lower),
      .upper_entry (upper),
      .cmp         (cmp),
      .valid       (cell_valid[g]),
      .entry       (cell_entry[g]),
      .match       (cell_match[g])
    );
  end

  // Checks
  `RWRQ_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_CNT, "count above queue depth")
  `RWRQ_ASSERT_NOW(a_hit_needs_reorder, (state == ST_EXEC) && (hit != '0),
                   !req_is_deq && ((req_entry.op == OP_READ) || (req_entry.op == OP_WRITE)),
                   "partner hit on a request that never reorders")
  `RWRQ_ASSERT_NEXT(a_enq_grows, commit && !req_is_deq && !queue_full,
                    count == $past(count) + CW'(1), "accepted enqueue did not grow count")
  `RWRQ_ASSERT_NEXT(a_deq_head, commit && req_is_deq && (count != '0),
                    m_tvalid && (out_head == $past(cell_entry[0])),
                    "dequeue result is not the old head")

endmodule

`default_nettype wire
